// File: design/ipdp_pkg.sv
// ----------------------------------------------------------------------------
// ipdp_pkg
// shared constants, types and helpers of the pointer dot packer
// ----------------------------------------------------------------------------
package ipdp_pkg;

    localparam int CFG_DATA_W = 10;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_X_CENTER    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_X_HALF_SPAN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_CENTER    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_HALF_SPAN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DOT_HALF_SEP = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DOT_SIZE    = 3'd5;

    localparam logic [9:0] RST_X_CENTER     = 10'd512;
    localparam logic [8:0] RST_X_HALF_SPAN  = 9'd296;
    localparam logic [9:0] RST_Y_CENTER     = 10'd487;
    localparam logic [8:0] RST_Y_HALF_SPAN  = 9'd165;
    localparam logic [8:0] RST_DOT_HALF_SEP = 9'd128;
    localparam logic [3:0] RST_DOT_SIZE     = 4'd4;

    localparam logic [16:0] Q_ONE  = 17'h10000;
    localparam logic [16:0] Q_HALF = 17'h08000;

    localparam logic [9:0] X_MAX    = 10'd1023;
    localparam logic [9:0] Y_MAX    = 10'd767;
    localparam logic [9:0] COORD_NONE = 10'h3FF;
    localparam logic [7:0] BYTE_NONE  = 8'hFF;

    localparam logic MODE_EXTENDED = 1'b0;
    localparam logic MODE_BASIC    = 1'b1;

    localparam logic [3:0] BYTES_EXTENDED = 4'd12;
    localparam logic [3:0] BYTES_BASIC    = 4'd10;

    typedef struct packed {
        logic       active;
        logic       mode;
        logic [3:0] size;
        logic [9:0] x0;
        logic [9:0] x1;
        logic [9:0] y;
    } dot_info_t;

    // distance of a q1.16 position from one half
    function automatic logic [15:0] offset_mag(input logic [16:0] q);
        logic [16:0] diff;
        begin
            if (q >= Q_HALF)
            begin
                diff = q - Q_HALF;
            end
            else
            begin
                diff = Q_HALF - q;
            end
            return diff[15:0];
        end
    endfunction

    // clamp a signed 12-bit value to 0..1023
    function automatic logic [9:0] clamp_x(input logic [11:0] v);
        begin
            if (v[11])
            begin
                return 10'd0;
            end
            else if (v[10])
            begin
                return X_MAX;
            end
            else
            begin
                return v[9:0];
            end
        end
    endfunction

    // clamp a signed 12-bit value to 0..767
    function automatic logic [9:0] clamp_y(input logic [11:0] v);
        begin
            if (v[11])
            begin
                return 10'd0;
            end
            else if (v[10:0] > {1'b0, Y_MAX})
            begin
                return Y_MAX;
            end
            else
            begin
                return v[9:0];
            end
        end
    endfunction

endpackage

// File: design/ipdp_pack.sv
// ----------------------------------------------------------------------------
// ipdp_pack
// packs two dots into the extended 12-byte or basic 10-byte camera report
// ----------------------------------------------------------------------------
module ipdp_pack (
    input  ipdp_pkg::dot_info_t dots,
    output logic [63:0]         packed_low,
    output logic [31:0]         packed_high
);

    logic [7:0] rep [12];
    logic [9:0] xa;
    logic [9:0] xb;
    logic [9:0] yab;

    always_comb
    begin
        xa  = dots.active ? dots.x0 : ipdp_pkg::COORD_NONE;
        xb  = dots.active ? dots.x1 : ipdp_pkg::COORD_NONE;
        yab = dots.active ? dots.y  : ipdp_pkg::COORD_NONE;
        for (int i = 0; i < 12; i++)
        begin
            rep[i] = ipdp_pkg::BYTE_NONE;
        end
        unique case (dots.mode)
            ipdp_pkg::MODE_BASIC:
            begin
                rep[0]  = xa[7:0];
                rep[1]  = yab[7:0];
                rep[2]  = {yab[9:8], xa[9:8], yab[9:8], xb[9:8]};
                rep[3]  = xb[7:0];
                rep[4]  = yab[7:0];
                rep[10] = 8'h00;
                rep[11] = 8'h00;
            end
            default:
            begin
                if (dots.active)
                begin
                    rep[0] = dots.x0[7:0];
                    rep[1] = dots.y[7:0];
                    rep[2] = {dots.y[9:8], dots.x0[9:8], dots.size};
                    rep[3] = dots.x1[7:0];
                    rep[4] = dots.y[7:0];
                    rep[5] = {dots.y[9:8], dots.x1[9:8], dots.size};
                end
            end
        endcase
    end

    assign packed_low  = {rep[7], rep[6], rep[5], rep[4], rep[3], rep[2], rep[1], rep[0]};
    assign packed_high = {rep[11], rep[10], rep[9], rep[8]};

endmodule

// File: design/ir_pointer_dot_packer.sv
// ----------------------------------------------------------------------------
// ir_pointer_dot_packer
// maps a q1.16 pointer position to two camera dots and packs the ir report
// ----------------------------------------------------------------------------
// usage
//   input channel: pointer_x, pointer_y, pointer_active, mode with in_valid,
//   in_stall; a transaction completes when in_valid is high and in_stall low
//   output channel: dot coordinates, packed report bytes and byte_count with
//   out_valid, out_stall; same transaction rule
//   config: cfg_we, cfg_index, cfg_data write one register per clock, only
//   while no transaction is in flight
//   pipeline: the input transaction passes the input register, product
//   register and result register before out_valid rises; one transaction per
//   cycle sustained while out_stall is low, with the single 16x10 multiply per
//   axis between the first two registers
//   reset: pipeline empties, config registers take their default values
//   stall: out_stall holds the result register; the pipeline keeps filling
//   its three stages, then raises in_stall
// ----------------------------------------------------------------------------
module ir_pointer_dot_packer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ipdp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ipdp_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [16:0]                         pointer_x,
    input  logic [16:0]                         pointer_y,
    input  logic                                pointer_active,
    input  logic                                mode,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [9:0]                          dot0_x,
    output logic [9:0]                          dot0_y,
    output logic [9:0]                          dot1_x,
    output logic [9:0]                          dot1_y,
    output logic [63:0]                         packed_low,
    output logic [31:0]                         packed_high,
    output logic [3:0]                          byte_count
);

    // configuration
    logic [9:0] x_center_reg;
    logic [8:0] x_half_span_reg;
    logic [9:0] y_center_reg;
    logic [8:0] y_half_span_reg;
    logic [8:0] dot_half_sep_reg;
    logic [3:0] dot_size_reg;

    // pipeline control
    logic a_valid_reg;
    logic b_valid_reg;
    logic out_valid_reg;
    logic adv_a;
    logic adv_b;
    logic adv_o;

    // input stage
    logic [16:0] a_x_reg;
    logic [16:0] a_y_reg;
    logic        a_active_reg;
    logic        a_mode_reg;
    logic [16:0] px_sat;
    logic [16:0] py_sat;

    // product stage
    logic [15:0] mag_x;
    logic [15:0] mag_y;
    logic [25:0] prod_x;
    logic [25:0] prod_y;
    logic [9:0]  b_px_reg;
    logic [9:0]  b_py_reg;
    logic        b_nx_reg;
    logic        b_ny_reg;
    logic        b_active_reg;
    logic        b_mode_reg;

    // result stage
    logic [11:0]         midx;
    logic [11:0]         midy;
    logic [11:0]         low_x;
    logic [11:0]         high_x;
    ipdp_pkg::dot_info_t dots;
    logic [63:0]         packed_low_next;
    logic [31:0]         packed_high_next;
    logic [9:0]          dot0_x_reg;
    logic [9:0]          dot1_x_reg;
    logic [9:0]          dot_y_reg;
    logic [63:0]         packed_low_reg;
    logic [31:0]         packed_high_reg;
    logic [3:0]          byte_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_center_reg     <= ipdp_pkg::RST_X_CENTER;
            x_half_span_reg  <= ipdp_pkg::RST_X_HALF_SPAN;
            y_center_reg     <= ipdp_pkg::RST_Y_CENTER;
            y_half_span_reg  <= ipdp_pkg::RST_Y_HALF_SPAN;
            dot_half_sep_reg <= ipdp_pkg::RST_DOT_HALF_SEP;
            dot_size_reg     <= ipdp_pkg::RST_DOT_SIZE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ipdp_pkg::CFG_X_CENTER:     x_center_reg     <= cfg_data;
                ipdp_pkg::CFG_X_HALF_SPAN:  x_half_span_reg  <= cfg_data[8:0];
                ipdp_pkg::CFG_Y_CENTER:     y_center_reg     <= cfg_data;
                ipdp_pkg::CFG_Y_HALF_SPAN:  y_half_span_reg  <= cfg_data[8:0];
                ipdp_pkg::CFG_DOT_HALF_SEP: dot_half_sep_reg <= cfg_data[8:0];
                ipdp_pkg::CFG_DOT_SIZE:     dot_size_reg     <= cfg_data[3:0];
                default:
                begin
                end
            endcase
        end
    end

    assign adv_o    = !out_valid_reg || !out_stall;
    assign adv_b    = !b_valid_reg || adv_o;
    assign adv_a    = !a_valid_reg || adv_b;
    assign in_stall = !adv_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_a)
            begin
                a_valid_reg <= in_valid;
            end
            if (adv_b)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (adv_o)
            begin
                out_valid_reg <= b_valid_reg;
            end
        end
    end

    // positions past one saturate to one
    assign px_sat = pointer_x[16] ? ipdp_pkg::Q_ONE : pointer_x;
    assign py_sat = pointer_y[16] ? ipdp_pkg::Q_ONE : pointer_y;

    always_ff @(posedge clk)
    begin
        if (adv_a)
        begin
            a_x_reg      <= px_sat;
            a_y_reg      <= py_sat;
            a_active_reg <= pointer_active;
            a_mode_reg   <= mode;
        end
    end

    assign mag_x  = ipdp_pkg::offset_mag(a_x_reg);
    assign mag_y  = ipdp_pkg::offset_mag(a_y_reg);
    assign prod_x = 26'(mag_x) * 26'({x_half_span_reg, 1'b0});
    assign prod_y = 26'(mag_y) * 26'({y_half_span_reg, 1'b0});

    always_ff @(posedge clk)
    begin
        if (adv_b)
        begin
            b_px_reg     <= prod_x[25:16];
            b_py_reg     <= prod_y[25:16];
            b_nx_reg     <= (a_x_reg > ipdp_pkg::Q_HALF);
            b_ny_reg     <= (a_y_reg < ipdp_pkg::Q_HALF);
            b_active_reg <= a_active_reg;
            b_mode_reg   <= a_mode_reg;
        end
    end

    // x axis mirrored, truncation toward zero on the magnitude
    always_comb
    begin
        if (b_nx_reg)
        begin
            midx = {2'b00, x_center_reg} - {2'b00, b_px_reg};
        end
        else
        begin
            midx = {2'b00, x_center_reg} + {2'b00, b_px_reg};
        end
        if (b_ny_reg)
        begin
            midy = {2'b00, y_center_reg} - {2'b00, b_py_reg};
        end
        else
        begin
            midy = {2'b00, y_center_reg} + {2'b00, b_py_reg};
        end
        low_x  = midx - {3'b000, dot_half_sep_reg};
        high_x = midx + {3'b000, dot_half_sep_reg};

        dots.active = b_active_reg;
        dots.mode   = b_mode_reg;
        dots.size   = dot_size_reg;
        if (b_active_reg)
        begin
            dots.x0 = ipdp_pkg::clamp_x(low_x);
            dots.x1 = ipdp_pkg::clamp_x(high_x);
            dots.y  = ipdp_pkg::clamp_y(midy);
        end
        else
        begin
            dots.x0 = ipdp_pkg::X_MAX;
            dots.x1 = ipdp_pkg::X_MAX;
            dots.y  = 10'd0;
        end
    end

    ipdp_pack u_pack (
        .dots        (dots),
        .packed_low  (packed_low_next),
        .packed_high (packed_high_next)
    );

    always_ff @(posedge clk)
    begin
        if (adv_o)
        begin
            dot0_x_reg      <= dots.x0;
            dot1_x_reg      <= dots.x1;
            dot_y_reg       <= dots.y;
            packed_low_reg  <= packed_low_next;
            packed_high_reg <= packed_high_next;
            byte_count_reg  <= (b_mode_reg == ipdp_pkg::MODE_BASIC) ?
                               ipdp_pkg::BYTES_BASIC : ipdp_pkg::BYTES_EXTENDED;
        end
    end

    assign out_valid   = out_valid_reg;
    assign dot0_x      = dot0_x_reg;
    assign dot1_x      = dot1_x_reg;
    assign dot0_y      = dot_y_reg;
    assign dot1_y      = dot_y_reg;
    assign packed_low  = packed_low_reg;
    assign packed_high = packed_high_reg;
    assign byte_count  = byte_count_reg;

`ifndef SYNTHESIS
    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (a_valid_reg && b_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled with room in the pipeline");

    a_dot_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (dot0_x <= dot1_x))
        else $error("lower dot right of upper dot");

    a_y_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (dot0_y <= ipdp_pkg::Y_MAX))
        else $error("dot y out of camera grid");

    a_basic_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (byte_count == ipdp_pkg::BYTES_BASIC)) |-> (packed_high[31:16] == 16'h0))
        else $error("basic report carries bytes past ten");
`endif

endmodule

// File: bench/ir_pointer_dot_packer_tb.sv
// ----------------------------------------------------------------------------
// ir_pointer_dot_packer_tb
// self-checking bench: random bursts in, stall pattern out, every result
// checked against a predicted report, register settings changed while idle
// ----------------------------------------------------------------------------
module ir_pointer_dot_packer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_PHASES     = 12;
    localparam int RANDOM_PER_SET = 150;
    localparam int MAX_REPORTED   = 10;

    typedef struct {
        logic [9:0]  d0x;
        logic [9:0]  d0y;
        logic [9:0]  d1x;
        logic [9:0]  d1y;
        logic [63:0] lo;
        logic [31:0] hi;
        logic [3:0]  cnt;
    } dot_report_t;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_style_t;

    class dot_report_checker;
        logic [9:0]  x_center;
        logic [8:0]  x_half_span;
        logic [9:0]  y_center;
        logic [8:0]  y_half_span;
        logic [8:0]  dot_half_sep;
        logic [3:0]  dot_size;
        dot_report_t pending_reports[$];
        int          errors;
        int          checked;
        int          samples;

        function new();
            x_center     = ipdp_pkg::RST_X_CENTER;
            x_half_span  = ipdp_pkg::RST_X_HALF_SPAN;
            y_center     = ipdp_pkg::RST_Y_CENTER;
            y_half_span  = ipdp_pkg::RST_Y_HALF_SPAN;
            dot_half_sep = ipdp_pkg::RST_DOT_HALF_SEP;
            dot_size     = ipdp_pkg::RST_DOT_SIZE;
            errors       = 0;
            checked      = 0;
            samples      = 0;
        endfunction

        function void set_reg(logic [ipdp_pkg::CFG_IDX_W-1:0] idx,
                              logic [ipdp_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                ipdp_pkg::CFG_X_CENTER:     x_center     = data[9:0];
                ipdp_pkg::CFG_X_HALF_SPAN:  x_half_span  = data[8:0];
                ipdp_pkg::CFG_Y_CENTER:     y_center     = data[9:0];
                ipdp_pkg::CFG_Y_HALF_SPAN:  y_half_span  = data[8:0];
                ipdp_pkg::CFG_DOT_HALF_SEP: dot_half_sep = data[8:0];
                ipdp_pkg::CFG_DOT_SIZE:     dot_size     = data[3:0];
                default: ;
            endcase
        endfunction

        // offset scaled by the span, truncated toward zero
        function int span_offset(int d, int span2);
            int mag;
            int p;
            mag = (d < 0) ? -d : d;
            p = (mag * span2) >>> 16;
            return (d < 0) ? -p : p;
        endfunction

        function int clamp_coord(int v, int hi);
            if (v < 0)
            begin
                return 0;
            end
            if (v > hi)
            begin
                return hi;
            end
            return v;
        endfunction

        function dot_report_t predict_report(logic [16:0] px, logic [16:0] py,
                                             logic act, logic md);
            dot_report_t r;
            int          sx;
            int          sy;
            int          mx;
            int          my;
            logic [9:0]  cx0;
            logic [9:0]  cx1;
            logic [9:0]  cy;
            logic [9:0]  ax;
            logic [9:0]  ay;
            logic [9:0]  bx;
            logic [9:0]  by;
            logic [7:0]  rb [12];
            sx = (px > ipdp_pkg::Q_ONE) ? int'(ipdp_pkg::Q_ONE) : int'(px);
            sy = (py > ipdp_pkg::Q_ONE) ? int'(ipdp_pkg::Q_ONE) : int'(py);
            cx0 = ipdp_pkg::X_MAX;
            cx1 = ipdp_pkg::X_MAX;
            cy  = 10'd0;
            if (act)
            begin
                mx = int'(x_center) + span_offset(int'(ipdp_pkg::Q_HALF) - sx,
                                                  2 * int'(x_half_span));
                my = int'(y_center) + span_offset(sy - int'(ipdp_pkg::Q_HALF),
                                                  2 * int'(y_half_span));
                cy  = 10'(clamp_coord(my, int'(ipdp_pkg::Y_MAX)));
                cx0 = 10'(clamp_coord(mx - int'(dot_half_sep), int'(ipdp_pkg::X_MAX)));
                cx1 = 10'(clamp_coord(mx + int'(dot_half_sep), int'(ipdp_pkg::X_MAX)));
            end
            for (int i = 0; i < 12; i++)
            begin
                rb[i] = ipdp_pkg::BYTE_NONE;
            end
            if (md == ipdp_pkg::MODE_BASIC)
            begin
                ax = act ? cx0 : ipdp_pkg::COORD_NONE;
                ay = act ? cy  : ipdp_pkg::COORD_NONE;
                bx = act ? cx1 : ipdp_pkg::COORD_NONE;
                by = act ? cy  : ipdp_pkg::COORD_NONE;
                rb[0]  = ax[7:0];
                rb[1]  = ay[7:0];
                rb[2]  = {ay[9:8], ax[9:8], by[9:8], bx[9:8]};
                rb[3]  = bx[7:0];
                rb[4]  = by[7:0];
                rb[10] = 8'd0;
                rb[11] = 8'd0;
                r.cnt  = ipdp_pkg::BYTES_BASIC;
            end
            else
            begin
                if (act)
                begin
                    rb[0] = cx0[7:0];
                    rb[1] = cy[7:0];
                    rb[2] = {cy[9:8], cx0[9:8], dot_size};
                    rb[3] = cx1[7:0];
                    rb[4] = cy[7:0];
                    rb[5] = {cy[9:8], cx1[9:8], dot_size};
                end
                r.cnt = ipdp_pkg::BYTES_EXTENDED;
            end
            r.d0x = cx0;
            r.d1x = cx1;
            r.d0y = cy;
            r.d1y = cy;
            r.lo  = {rb[7], rb[6], rb[5], rb[4], rb[3], rb[2], rb[1], rb[0]};
            r.hi  = {rb[11], rb[10], rb[9], rb[8]};
            return r;
        endfunction

        function void note_sample(logic [16:0] px, logic [16:0] py, logic act, logic md);
            pending_reports.push_back(predict_report(px, py, act, md));
            samples++;
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                errors++;
                if (errors <= MAX_REPORTED)
                begin
                    $display("mismatch on %s at %0t: expected %h, got %h",
                             name, $realtime, want, got);
                end
            end
        endfunction

        function void check_report(dot_report_t got);
            dot_report_t want;
            if (pending_reports.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTED)
                begin
                    $display("unexpected transaction at %0t: dot0_x %0d dot1_x %0d",
                             $realtime, got.d0x, got.d1x);
                end
                return;
            end
            want = pending_reports.pop_front();
            checked++;
            compare_field("dot0_x", 64'(want.d0x), 64'(got.d0x));
            compare_field("dot0_y", 64'(want.d0y), 64'(got.d0y));
            compare_field("dot1_x", 64'(want.d1x), 64'(got.d1x));
            compare_field("dot1_y", 64'(want.d1y), 64'(got.d1y));
            compare_field("packed_low", want.lo, got.lo);
            compare_field("packed_high", 64'(want.hi), 64'(got.hi));
            compare_field("byte_count", 64'(want.cnt), 64'(got.cnt));
        endfunction

        function int pending();
            return pending_reports.size();
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n          = 1'b0;
    logic                            cfg_we         = 1'b0;
    logic [ipdp_pkg::CFG_IDX_W-1:0]  cfg_index      = '0;
    logic [ipdp_pkg::CFG_DATA_W-1:0] cfg_data       = '0;
    logic                            in_valid       = 1'b0;
    logic                            in_stall;
    logic [16:0]                     pointer_x      = '0;
    logic [16:0]                     pointer_y      = '0;
    logic                            pointer_active = 1'b0;
    logic                            mode           = 1'b0;
    logic                            out_valid;
    logic                            out_stall      = 1'b0;
    logic [9:0]                      dot0_x;
    logic [9:0]                      dot0_y;
    logic [9:0]                      dot1_x;
    logic [9:0]                      dot1_y;
    logic [63:0]                     packed_low;
    logic [31:0]                     packed_high;
    logic [3:0]                      byte_count;

    dot_report_checker book;
    dot_report_t       seen;
    int                burst_left   = 0;
    int                settings     = 0;
    stall_style_t      stall_style  = STALL_NONE;
    int                stall_window = 0;

    ir_pointer_dot_packer uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .pointer_x      (pointer_x),
        .pointer_y      (pointer_y),
        .pointer_active (pointer_active),
        .mode           (mode),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .dot0_x         (dot0_x),
        .dot0_y         (dot0_y),
        .dot1_x         (dot1_x),
        .dot1_y         (dot1_y),
        .packed_low     (packed_low),
        .packed_high    (packed_high),
        .byte_count     (byte_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    // receiver stall pattern
    always @(posedge clk)
    begin
        if (stall_window == 0)
        begin
            stall_style  <= stall_style_t'($urandom_range(0, 3));
            stall_window <= $urandom_range(16, 200);
        end
        else
        begin
            stall_window <= stall_window - 1;
        end
        case (stall_style)
            STALL_NONE:     out_stall <= 1'b0;
            STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
            STALL_PERIODIC: out_stall <= ((stall_window % 5) < 2);
            default:        out_stall <= 1'b0;
        endcase
    end

    // transaction monitor: inputs are noted before results are checked
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                book.note_sample(pointer_x, pointer_y, pointer_active, mode);
            end
            if (out_valid && !out_stall)
            begin
                seen.d0x = dot0_x;
                seen.d0y = dot0_y;
                seen.d1x = dot1_x;
                seen.d1y = dot1_y;
                seen.lo  = packed_low;
                seen.hi  = packed_high;
                seen.cnt = byte_count;
                book.check_report(seen);
            end
        end
    end

    task automatic send_paced(logic [16:0] px, logic [16:0] py, logic act, logic md);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        pointer_x      <= px;
        pointer_y      <= py;
        pointer_active <= act;
        mode           <= md;
        in_valid       <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (book.pending() != 0) @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    task automatic write_reg(logic [ipdp_pkg::CFG_IDX_W-1:0] idx,
                             logic [ipdp_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        book.set_reg(idx, data);
    endtask

    task automatic configure(logic [9:0] xc, logic [8:0] xhs, logic [9:0] yc,
                             logic [8:0] yhs, logic [8:0] sep, logic [3:0] size);
        write_reg(ipdp_pkg::CFG_X_CENTER, ipdp_pkg::CFG_DATA_W'(xc));
        write_reg(ipdp_pkg::CFG_X_HALF_SPAN, ipdp_pkg::CFG_DATA_W'(xhs));
        write_reg(ipdp_pkg::CFG_Y_CENTER, ipdp_pkg::CFG_DATA_W'(yc));
        write_reg(ipdp_pkg::CFG_Y_HALF_SPAN, ipdp_pkg::CFG_DATA_W'(yhs));
        write_reg(ipdp_pkg::CFG_DOT_HALF_SEP, ipdp_pkg::CFG_DATA_W'(sep));
        write_reg(ipdp_pkg::CFG_DOT_SIZE, ipdp_pkg::CFG_DATA_W'(size));
        cfg_we <= 1'b0;
        settings++;
    endtask

    function automatic logic [16:0] rand_pos();
        int v;
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 2))
                    0:       v = 0;
                    1:       v = int'(ipdp_pkg::Q_HALF);
                    default: v = int'(ipdp_pkg::Q_ONE);
                endcase
            end
            1:       v = $urandom_range(int'(ipdp_pkg::Q_ONE) + 1, 131071);
            2:       v = int'(ipdp_pkg::Q_HALF) + $urandom_range(0, 64) - 32;
            default: v = $urandom_range(0, int'(ipdp_pkg::Q_ONE));
        endcase
        return 17'(v);
    endfunction

    initial
    begin
        int phase;
        int n;
        book = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_paced(ipdp_pkg::Q_HALF, ipdp_pkg::Q_HALF, 1'b1, ipdp_pkg::MODE_EXTENDED);
        send_paced(17'd0, 17'd0, 1'b1, ipdp_pkg::MODE_EXTENDED);
        send_paced(ipdp_pkg::Q_ONE, ipdp_pkg::Q_ONE, 1'b1, ipdp_pkg::MODE_EXTENDED);
        send_paced(17'd0, ipdp_pkg::Q_ONE, 1'b1, ipdp_pkg::MODE_BASIC);
        send_paced(ipdp_pkg::Q_ONE, 17'd0, 1'b1, ipdp_pkg::MODE_BASIC);
        send_paced(17'h1FFFF, 17'h1FFFF, 1'b1, ipdp_pkg::MODE_EXTENDED);
        send_paced(ipdp_pkg::Q_ONE + 17'd1, 17'd100000, 1'b1, ipdp_pkg::MODE_BASIC);
        send_paced(ipdp_pkg::Q_HALF - 17'd1, ipdp_pkg::Q_HALF + 17'd1, 1'b1,
                   ipdp_pkg::MODE_EXTENDED);
        send_paced(ipdp_pkg::Q_HALF + 17'd1, ipdp_pkg::Q_HALF - 17'd1, 1'b1,
                   ipdp_pkg::MODE_BASIC);
        send_paced(17'd1, ipdp_pkg::Q_ONE - 17'd1, 1'b1, ipdp_pkg::MODE_EXTENDED);
        send_paced(ipdp_pkg::Q_HALF, ipdp_pkg::Q_HALF, 1'b0, ipdp_pkg::MODE_EXTENDED);
        send_paced(17'd0, 17'h1FFFF, 1'b0, ipdp_pkg::MODE_BASIC);
        send_paced(17'h1FFFF, 17'd0, 1'b0, ipdp_pkg::MODE_EXTENDED);
        send_paced(ipdp_pkg::Q_ONE, ipdp_pkg::Q_HALF, 1'b0, ipdp_pkg::MODE_BASIC);
        drain();

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0:  configure(10'd0, 9'd511, 10'd0, 9'd383, 9'd511, 4'd15);
                1:  configure(ipdp_pkg::X_MAX, 9'd511, ipdp_pkg::Y_MAX, 9'd383, 9'd511, 4'd0);
                2:  configure(10'd0, 9'd0, 10'd0, 9'd0, 9'd0, 4'd0);
                3:  configure(ipdp_pkg::X_MAX, 9'd0, ipdp_pkg::Y_MAX, 9'd0, 9'd0, 4'd15);
                default:
                    configure(10'($urandom_range(0, 1023)), 9'($urandom_range(0, 511)),
                              10'($urandom_range(0, 767)), 9'($urandom_range(0, 383)),
                              9'($urandom_range(0, 511)), 4'($urandom_range(0, 15)));
            endcase
            send_paced(17'd0, 17'd0, 1'b1, ipdp_pkg::MODE_EXTENDED);
            send_paced(ipdp_pkg::Q_ONE, ipdp_pkg::Q_ONE, 1'b1, ipdp_pkg::MODE_BASIC);
            send_paced(17'd0, ipdp_pkg::Q_ONE, 1'b1, ipdp_pkg::MODE_BASIC);
            send_paced(ipdp_pkg::Q_ONE, 17'd0, 1'b1, ipdp_pkg::MODE_EXTENDED);
            for (n = 0; n < RANDOM_PER_SET; n++)
            begin
                send_paced(rand_pos(), rand_pos(), ($urandom_range(0, 7) != 0),
                           1'($urandom_range(0, 1)));
            end
            drain();
        end

        $display("covered %0d pointer samples over %0d register settings plus defaults,",
                 book.samples, settings);
        $display("both report formats, inactive pointers and saturated positions; %0d checked",
                 book.checked);
        if (book.errors == 0 && book.pending() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
